// ===== rtl/csd_pkg.sv =====
// Shared types and codes for the custom-attribute string decoder.
// No dependencies; compile first.
package csd_pkg;

	// Status codes reported on the last result of a blob
	localparam logic [2:0] OUTCOME_OK     = 3'd0;
	localparam logic [2:0] OUTCOME_NULL   = 3'd1;
	localparam logic [2:0] OUTCOME_PROLOG = 3'd2;
	localparam logic [2:0] OUTCOME_BADLEN = 3'd3;
	localparam logic [2:0] OUTCOME_TRUNC  = 3'd4;

	// Width of the decoded string length
	localparam int LEN_W = 29;

	// One result beat
	typedef struct packed {
		logic [7:0] string_byte;
		logic       byte_present;
		logic [2:0] outcome;
		logic       finished;
	} res_t;

endpackage

// ===== rtl/csd_blob_if.sv =====
// Input channel of the decoder: one blob byte per beat, with end flag.
// Depends on nothing.
interface csd_blob_if;
	logic       valid;
	logic       ready;
	logic [7:0] blob_byte;
	logic       blob_end;

	modport source(output valid, blob_byte, blob_end, input ready);
	modport sink(input valid, blob_byte, blob_end, output ready);
endinterface

// ===== rtl/csd_result_if.sv =====
// Output channel of the decoder: one string byte and/or status per beat.
// Depends on nothing.
interface csd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] string_byte;
	logic       byte_present;
	logic [2:0] outcome;
	logic       finished;

	modport source(output valid, string_byte, byte_present, outcome, finished, input ready);
	modport sink(input valid, string_byte, byte_present, outcome, finished, output ready);
endinterface

// ===== rtl/csd_skid.sv =====
// Two-entry output buffer of the decoder with a registered ready.
// Depends on csd_pkg and csd_result_if.
module csd_skid
	import csd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  res_t                push_data,
	output logic                space,
	csd_result_if.source        result
);

	logic main_v_q;
	logic skid_v_q;
	res_t main_q;
	res_t skid_q;

	// Accept while the skid entry is empty
	assign space = !skid_v_q;

	// Advance the main entry when it is free or taken; park a beat otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (result.ready || !main_v_q) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload follows the same moves, no reset
	always_ff @(posedge clk) begin
		if (result.ready || !main_v_q) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign result.valid        = main_v_q;
	assign result.string_byte  = main_q.string_byte;
	assign result.byte_present = main_q.byte_present;
	assign result.outcome      = main_q.outcome;
	assign result.finished     = main_q.finished;

endmodule

// ===== rtl/custom_attribute_string_decoder.sv =====
// Custom-attribute string decoder: checks the 01 00 prolog, decodes a
// compressed length or null marker, then passes the string bytes out.
// Each result is registered in the output buffer before it appears.
// Throughput: one byte per cycle; ready drops only when both output
// buffer entries are full. Reset (arst_n low) returns the parser to the
// first prolog byte and empties the output buffer.
module custom_attribute_string_decoder
	import csd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	csd_blob_if.sink     blob,
	csd_result_if.source result
);

	// Parser phases
	localparam logic [2:0] PH_PROLOG0 = 3'd0;
	localparam logic [2:0] PH_PROLOG1 = 3'd1;
	localparam logic [2:0] PH_LEN0    = 3'd2;
	localparam logic [2:0] PH_LENX    = 3'd3;
	localparam logic [2:0] PH_CHARS   = 3'd4;
	localparam logic [2:0] PH_DRAIN   = 3'd5;

	logic [2:0]       phase_q;
	logic [LEN_W-1:0] len_acc_q;
	logic [1:0]       len_left_q;
	logic [LEN_W-1:0] chars_left_q;

	logic [2:0]       phase_d;
	logic [LEN_W-1:0] len_acc_d;
	logic [1:0]       len_left_d;
	logic [LEN_W-1:0] chars_left_d;

	logic             accept;
	logic             space;
	logic             emit;
	res_t             res;
	logic [7:0]       b;
	logic             last;
	logic [LEN_W-1:0] acc_shift;
	logic [1:0]       left_dec;
	logic [LEN_W-1:0] chars_dec;

	assign blob.ready = space;
	assign accept     = blob.valid && space;
	assign b          = blob.blob_byte;
	assign last       = blob.blob_end;
	assign acc_shift  = {len_acc_q[LEN_W-9:0], b};
	assign left_dec   = len_left_q - 2'd1;
	assign chars_dec  = chars_left_q - LEN_W'(1);

	// Decode one byte against the current phase
	always_comb begin
		phase_d      = phase_q;
		len_acc_d    = len_acc_q;
		len_left_d   = len_left_q;
		chars_left_d = chars_left_q;
		emit         = 1'b0;
		res          = '0;
		case (phase_q)
			PH_PROLOG0: begin
				if (b != 8'h01) begin
					emit = 1'b1;
					res.outcome = OUTCOME_PROLOG;
				end else if (last) begin
					emit = 1'b1;
					res.outcome = OUTCOME_TRUNC;
				end else begin
					phase_d = PH_PROLOG1;
				end
			end
			PH_PROLOG1: begin
				if (b != 8'h00) begin
					emit = 1'b1;
					res.outcome = OUTCOME_PROLOG;
				end else if (last) begin
					emit = 1'b1;
					res.outcome = OUTCOME_TRUNC;
				end else begin
					phase_d = PH_LEN0;
				end
			end
			PH_LEN0: begin
				if (b == 8'hFF) begin
					emit = 1'b1;
					res.outcome = OUTCOME_NULL;
				end else if (b[7] == 1'b0) begin
					// One-byte length
					if (b == 8'h00) begin
						emit = 1'b1;
						res.outcome = OUTCOME_OK;
					end else if (last) begin
						emit = 1'b1;
						res.outcome = OUTCOME_TRUNC;
					end else begin
						chars_left_d = LEN_W'(b);
						phase_d = PH_CHARS;
					end
				end else if ((b & 8'hC0) == 8'h80 || (b & 8'hE0) == 8'hC0) begin
					// Two- or four-byte length lead
					if (b[6] == 1'b0) begin
						len_acc_d  = LEN_W'(b & 8'h3F);
						len_left_d = 2'd1;
					end else begin
						len_acc_d  = LEN_W'(b & 8'h1F);
						len_left_d = 2'd3;
					end
					if (last) begin
						emit = 1'b1;
						res.outcome = OUTCOME_TRUNC;
					end else begin
						phase_d = PH_LENX;
					end
				end else begin
					emit = 1'b1;
					res.outcome = OUTCOME_BADLEN;
				end
			end
			PH_LENX: begin
				len_acc_d  = acc_shift;
				len_left_d = left_dec;
				if (left_dec == 2'd0) begin
					if (acc_shift == '0) begin
						emit = 1'b1;
						res.outcome = OUTCOME_OK;
					end else if (last) begin
						emit = 1'b1;
						res.outcome = OUTCOME_TRUNC;
					end else begin
						chars_left_d = acc_shift;
						phase_d = PH_CHARS;
					end
				end else if (last) begin
					emit = 1'b1;
					res.outcome = OUTCOME_TRUNC;
				end
			end
			PH_CHARS: begin
				chars_left_d = chars_dec;
				if (chars_dec == '0) begin
					emit = 1'b1;
					res.string_byte  = b;
					res.byte_present = 1'b1;
					res.outcome      = OUTCOME_OK;
				end else if (last) begin
					emit = 1'b1;
					res.outcome = OUTCOME_TRUNC;
				end else begin
					res.string_byte  = b;
					res.byte_present = 1'b1;
				end
			end
			default: begin
				// Drop bytes until blob end
				if (last) begin
					phase_d = PH_PROLOG0;
				end
			end
		endcase
		// A status closes the blob: restart or drain the rest
		if (emit) begin
			res.finished = 1'b1;
			phase_d      = last ? PH_PROLOG0 : PH_DRAIN;
		end
	end

	// Hold parser state between beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PROLOG0;
			len_acc_q    <= '0;
			len_left_q   <= '0;
			chars_left_q <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			len_acc_q    <= len_acc_d;
			len_left_q   <= len_left_d;
			chars_left_q <= chars_left_d;
		end
	end

	csd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && (emit || res.byte_present)),
		.push_data (res),
		.space     (space),
		.result    (result)
	);

endmodule
